// ===== hdl/http_chunked_body_decoder_core_macros.svh =====
// ----------------------------------------------------------------------------
// http chunked body decoder - assertion macros
// shared concurrent assertion forms for the decoder core
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_CORE_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define HCBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hcbd assertion failed");

// next-cycle implication, disabled while reset is held
`define HCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hcbd assertion failed");

`endif

// ===== hdl/hcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbd_pkg
// types, constants and helpers for the chunked body decoder
// ----------------------------------------------------------------------------
`default_nettype none

package hcbd_pkg;

    localparam int SIZE_BITS = 32;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef enum logic [6:0] {
        PH_SIZE    = 7'b0000001,
        PH_EXT     = 7'b0000010,
        PH_SIZE_LF = 7'b0000100,
        PH_DATA    = 7'b0001000,
        PH_DATA_CR = 7'b0010000,
        PH_DATA_LF = 7'b0100000,
        PH_DONE    = 7'b1000000
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SATURATED = 2'd1,
        ST_FRAMING   = 2'd2
    } t_status;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       chunk_last;
        logic       body_done;
        t_status    status;
    } t_result;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.is_hex = 1'b1;
        h.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            h.value = c[3:0] + 4'd9;
        end else begin
            h.is_hex = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/hcbd_in_if.sv =====
// ----------------------------------------------------------------------------
// hcbd_in_if
// input channel of the decoder: one raw body byte per item
// ----------------------------------------------------------------------------
`default_nettype none

interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       start_of_body;

    modport source (output valid, output in_byte, output start_of_body, input ready);
    modport sink   (input valid, input in_byte, input start_of_body, output ready);
endinterface

`default_nettype wire

// ===== hdl/hcbd_out_if.sv =====
// ----------------------------------------------------------------------------
// hcbd_out_if
// result channel of the decoder: one result per accepted input item
// ----------------------------------------------------------------------------
`default_nettype none

interface hcbd_out_if;
    logic                valid;
    logic                ready;
    logic                out_valid;
    logic [7:0]          out_byte;
    logic                chunk_last;
    logic                body_done;
    logic [1:0]          status;

    modport source (output valid, output out_valid, output out_byte, output chunk_last,
                    output body_done, output status, input ready);
    modport sink   (input valid, input out_valid, input out_byte, input chunk_last,
                    input body_done, input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/http_chunked_body_decoder_core.sv =====
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core
// streaming decoder for an http/1.1 chunked body, one byte per item
// ----------------------------------------------------------------------------
// usage
//   i_in carries raw body bytes with a start_of_body flag that restarts the
//   parser on that byte. o_out returns exactly one result per input item:
//   a data byte flag with the byte, chunk_last on the final byte of a chunk,
//   body_done on the lf of the zero-size line and a status code.
//   latency: the result is shown on the cycle after the item is accepted.
//   throughput: one item per cycle unless a waiting result is held by
//   o_out.ready low; parser state and result both update on acceptance.
//   reset: i_rst_n low (synchronous) empties the result register and puts
//   the parser at the start of a size line.
//   stall: while o_out.ready is low a waiting result holds and i_in.ready
//   drops; i_in.ready stays high whenever the result register is empty or
//   is being taken in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "http_chunked_body_decoder_core_macros.svh"

module http_chunked_body_decoder_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    hcbd_in_if.sink     i_in,
    hcbd_out_if.source  o_out
);

    localparam int SB = hcbd_pkg::SIZE_BITS;

    hcbd_pkg::t_phase  r_phase, n_phase;
    logic [SB-1:0]     r_remaining, n_remaining;
    logic              r_saw_digit, n_saw_digit;
    logic              r_out_vld;
    hcbd_pkg::t_result r_res, n_res;

    hcbd_pkg::t_phase  w_phase;
    logic [SB-1:0]     w_rem;
    logic              w_saw;
    logic [SB-1:0]     w_rem_dec;
    hcbd_pkg::t_hex    w_hex;
    logic              w_accept;

    assign i_in.ready = !r_out_vld || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    // start of body restarts the line before the byte is handled
    assign w_phase   = i_in.start_of_body ? hcbd_pkg::PH_SIZE : r_phase;
    assign w_rem     = i_in.start_of_body ? '0 : r_remaining;
    assign w_saw     = i_in.start_of_body ? 1'b0 : r_saw_digit;
    assign w_rem_dec = (w_rem != '0) ? w_rem - SB'(1) : w_rem;
    assign w_hex     = hcbd_pkg::hex_decode(i_in.in_byte);

    always_comb begin
        n_phase     = w_phase;
        n_remaining = w_rem;
        n_saw_digit = w_saw;
        n_res       = '{out_valid: 1'b0, out_byte: 8'd0, chunk_last: 1'b0,
                        body_done: 1'b0, status: hcbd_pkg::ST_OK};
        unique case (w_phase)
            hcbd_pkg::PH_SIZE: begin
                if (w_hex.is_hex) begin
                    n_saw_digit = 1'b1;
                    if (w_rem[SB-1 -: 4] != 4'd0) begin
                        n_remaining  = '1;
                        n_res.status = hcbd_pkg::ST_SATURATED;
                    end else begin
                        n_remaining = {w_rem[SB-5:0], w_hex.value};
                    end
                end else if (i_in.in_byte == hcbd_pkg::CH_CR) begin
                    n_phase = hcbd_pkg::PH_SIZE_LF;
                end else begin
                    n_phase = hcbd_pkg::PH_EXT;
                end
            end
            hcbd_pkg::PH_EXT: begin
                if (i_in.in_byte == hcbd_pkg::CH_CR) begin
                    n_phase = hcbd_pkg::PH_SIZE_LF;
                end
            end
            hcbd_pkg::PH_SIZE_LF: begin
                if (i_in.in_byte == hcbd_pkg::CH_LF) begin
                    if (!w_saw) begin
                        n_res.status = hcbd_pkg::ST_FRAMING;
                        n_phase      = hcbd_pkg::PH_SIZE;
                        n_remaining  = '0;
                        n_saw_digit  = 1'b0;
                    end else if (w_rem == '0) begin
                        n_res.body_done = 1'b1;
                        n_phase         = hcbd_pkg::PH_DONE;
                    end else begin
                        n_phase = hcbd_pkg::PH_DATA;
                    end
                end else if (i_in.in_byte != hcbd_pkg::CH_CR) begin
                    n_res.status = hcbd_pkg::ST_FRAMING;
                    n_phase      = hcbd_pkg::PH_SIZE;
                    n_remaining  = '0;
                    n_saw_digit  = 1'b0;
                end
            end
            hcbd_pkg::PH_DATA: begin
                n_res.out_valid = 1'b1;
                n_res.out_byte  = i_in.in_byte;
                n_remaining     = w_rem_dec;
                if (w_rem_dec == '0) begin
                    n_res.chunk_last = 1'b1;
                    n_phase          = hcbd_pkg::PH_DATA_CR;
                end
            end
            hcbd_pkg::PH_DATA_CR: begin
                if (i_in.in_byte == hcbd_pkg::CH_CR) begin
                    n_phase = hcbd_pkg::PH_DATA_LF;
                end else begin
                    n_res.status = hcbd_pkg::ST_FRAMING;
                    n_phase      = hcbd_pkg::PH_SIZE;
                    n_remaining  = '0;
                    n_saw_digit  = 1'b0;
                end
            end
            hcbd_pkg::PH_DATA_LF: begin
                if (i_in.in_byte != hcbd_pkg::CH_LF) begin
                    n_res.status = hcbd_pkg::ST_FRAMING;
                end
                n_phase     = hcbd_pkg::PH_SIZE;
                n_remaining = '0;
                n_saw_digit = 1'b0;
            end
            default: begin
                n_phase = hcbd_pkg::PH_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= hcbd_pkg::PH_SIZE;
            r_remaining <= '0;
            r_saw_digit <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase     <= n_phase;
                r_remaining <= n_remaining;
                r_saw_digit <= n_saw_digit;
                r_out_vld   <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.out_valid  = r_res.out_valid;
    assign o_out.out_byte   = r_res.out_byte;
    assign o_out.chunk_last = r_res.chunk_last;
    assign o_out.body_done  = r_res.body_done;
    assign o_out.status     = r_res.status;

    // data items carry no error and no end of body
    `HCBD_ASSERT_NOW(a_data_clean, i_clk, i_rst_n, r_out_vld && r_res.out_valid, r_res.status == hcbd_pkg::ST_OK && !r_res.body_done)
    // chunk end only on a data item
    `HCBD_ASSERT_NOW(a_last_on_data, i_clk, i_rst_n, r_out_vld && r_res.chunk_last, r_res.out_valid)
    // a shown end of body leaves the parser parked
    `HCBD_ASSERT_NOW(a_done_parks, i_clk, i_rst_n, r_out_vld && r_res.body_done, r_phase == hcbd_pkg::PH_DONE)
    // data phase always has bytes left to pass
    `HCBD_ASSERT_NOW(a_data_count, i_clk, i_rst_n, r_phase == hcbd_pkg::PH_DATA, r_remaining != '0)
    // once parked, bytes come back empty until restarted
    `HCBD_ASSERT_NEXT(a_parked_quiet, i_clk, i_rst_n, w_accept && r_phase == hcbd_pkg::PH_DONE && !i_in.start_of_body, r_out_vld && !r_res.out_valid && !r_res.body_done && r_res.status == hcbd_pkg::ST_OK)

endmodule

`default_nettype wire

// ===== tb/hcbd_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hcbd_result_checker
// watches both channels of the chunked body decoder, keeps its own parser
// state to work out the result of every accepted byte and compares each
// returned result, field by field, with the oldest one still owed
// ----------------------------------------------------------------------------

module hcbd_result_checker
    import hcbd_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    hcbd_in_if   i_in_mon,
    hcbd_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);

    t_phase                 ph;
    logic [SIZE_BITS-1:0]   size_cnt;
    logic                   got_digit;
    t_result                results_due[$];
    int                     mismatches = 0;
    int                     due_count  = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = due_count;

    function automatic void restart_line();
        ph        = PH_SIZE;
        size_cnt  = '0;
        got_digit = 1'b0;
    endfunction

    // bit 4 flags a hex digit, bits 3:0 hold its value
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b1, 4'(c - 8'h30)};
        if (c >= "A" && c <= "F") return {1'b1, 4'(c - 8'h37)};
        if (c >= "a" && c <= "f") return {1'b1, 4'(c - 8'h57)};
        return 5'd0;
    endfunction

    function automatic t_result decode_byte(input logic [7:0] b, input logic sob);
        t_result    r;
        logic [4:0] nib;
        r        = '0;
        r.status = ST_OK;
        if (sob) restart_line();
        case (ph)
            PH_SIZE: begin
                nib = digit_of(b);
                if (nib[4]) begin
                    got_digit = 1'b1;
                    if (size_cnt[SIZE_BITS-1 -: 4] != 4'd0) begin
                        size_cnt = '1;
                        r.status = ST_SATURATED;
                    end else begin
                        size_cnt = {size_cnt[SIZE_BITS-5:0], nib[3:0]};
                    end
                end else if (b == CH_CR) begin
                    ph = PH_SIZE_LF;
                end else begin
                    ph = PH_EXT;
                end
            end
            PH_EXT: begin
                if (b == CH_CR) ph = PH_SIZE_LF;
            end
            PH_SIZE_LF: begin
                if (b == CH_LF) begin
                    if (!got_digit) begin
                        r.status = ST_FRAMING;
                        restart_line();
                    end else if (size_cnt == '0) begin
                        r.body_done = 1'b1;
                        ph          = PH_DONE;
                    end else begin
                        ph = PH_DATA;
                    end
                end else if (b != CH_CR) begin
                    r.status = ST_FRAMING;
                    restart_line();
                end
            end
            PH_DATA: begin
                r.out_valid = 1'b1;
                r.out_byte  = b;
                if (size_cnt != '0) size_cnt = size_cnt - 1'b1;
                if (size_cnt == '0) begin
                    r.chunk_last = 1'b1;
                    ph           = PH_DATA_CR;
                end
            end
            PH_DATA_CR: begin
                if (b == CH_CR) begin
                    ph = PH_DATA_LF;
                end else begin
                    r.status = ST_FRAMING;
                    restart_line();
                end
            end
            PH_DATA_LF: begin
                if (b != CH_LF) r.status = ST_FRAMING;
                restart_line();
            end
            default: ph = PH_DONE;
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
        $display("[%0t] %s mismatch: got %0h, expected %0h", $time, field, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            restart_line();
            results_due.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (results_due.size() == 0) begin
                    flag_mismatch("unexpected result", i_out_mon.out_byte, 8'h00);
                end else begin
                    want = results_due.pop_front();
                    if (i_out_mon.out_valid !== want.out_valid)
                        flag_mismatch("out_valid", 8'(i_out_mon.out_valid), 8'(want.out_valid));
                    if (i_out_mon.out_byte !== want.out_byte)
                        flag_mismatch("out_byte", i_out_mon.out_byte, want.out_byte);
                    if (i_out_mon.chunk_last !== want.chunk_last)
                        flag_mismatch("chunk_last", 8'(i_out_mon.chunk_last),
                                      8'(want.chunk_last));
                    if (i_out_mon.body_done !== want.body_done)
                        flag_mismatch("body_done", 8'(i_out_mon.body_done), 8'(want.body_done));
                    if (i_out_mon.status !== want.status)
                        flag_mismatch("status", 8'(i_out_mon.status), 8'(want.status));
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                results_due.push_back(decode_byte(i_in_mon.in_byte, i_in_mon.start_of_body));
        end
        due_count <= results_due.size();
    end

endmodule

// ===== tb/tb_http_chunked_body_decoder_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder_core
// drives chunked bodies into the decoder: a directed run over the framing
// corner cases, then random bodies that are mostly well formed, with broken
// framing, noise and oversize lines mixed in, under random idling on both
// channels; results are checked by hcbd_result_checker
// ----------------------------------------------------------------------------

module tb_http_chunked_body_decoder_core;
    import hcbd_pkg::*;

    logic i_clk;
    logic i_rst_n;

    hcbd_in_if  in_ch ();
    hcbd_out_if out_ch ();

    int fail_count;
    int pending_results;
    bit start_pending = 1'b0;
    bit idle_on       = 1'b1;
    int corrupt_left  = -1;
    int counted_items = 0;

    http_chunked_body_decoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    hcbd_result_checker checker_u (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #4ms;
        $display("** http_chunked_body_decoder_core: FAILED **");
        $finish;
    end

    // result side back-pressure
    initial begin
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return (upper ? 8'h37 : 8'h57) + 8'(n);
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 5))
            0: return CH_CR;
            1: return CH_LF;
            2: return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            3: return 8'h3B;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit counts);
        logic [7:0] v;
        v = b;
        if (counts && corrupt_left == 0) v = noise_byte();
        if (counts && corrupt_left >= 0) corrupt_left--;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.in_byte       <= v;
        in_ch.start_of_body <= start_pending;
        start_pending = 1'b0;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (counts) counted_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b1);
    endtask

    task automatic send_crlf();
        send_byte(CH_CR, 1'b1);
        send_byte(CH_LF, 1'b1);
    endtask

    task automatic send_size_line(input logic [31:0] sz, input bit ext);
        int         top_nib;
        bit         upper;
        logic [7:0] eb;
        upper   = 1'($urandom_range(0, 1));
        top_nib = 0;
        for (int i = 7; i > 0; i--)
            if (sz[4*i +: 4] != 4'd0 && top_nib == 0) top_nib = i;
        repeat ($urandom_range(0, 2)) send_byte("0", 1'b1);
        for (int i = top_nib; i >= 0; i--) send_byte(hex_char(sz[4*i +: 4], upper), 1'b1);
        if (ext) begin
            send_byte($urandom_range(0, 1) ? 8'h3B : 8'h20, 1'b1);
            repeat ($urandom_range(0, 5)) begin
                eb = 8'($urandom_range(0, 254));
                send_byte((eb == CH_CR) ? 8'hFF : eb, 1'b1);
            end
        end
        send_crlf();
    endtask

    task automatic send_chunk(input int sz, input bit ext);
        send_size_line(sz, ext);
        repeat (sz) send_byte(8'($urandom_range(0, 255)), 1'b1);
        send_crlf();
    endtask

    task automatic send_body(input bit broken);
        int sz;
        start_pending = 1'b1;
        if (broken) corrupt_left = $urandom_range(0, 20);
        repeat ($urandom_range(0, 4)) begin
            sz = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
            send_chunk(sz, $urandom_range(0, 4) == 0);
        end
        send_size_line(0, $urandom_range(0, 4) == 0);
        corrupt_left = -1;
        // trailer bytes after the last chunk are dropped
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic send_noise();
        start_pending = 1'b1;
        repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(0, 7) == 0) start_pending = 1'b1;
            send_byte(noise_byte(), 1'b1);
        end
    endtask

    // long size lines, some saturating, cut short by the next body
    task automatic send_oversize();
        start_pending = 1'b1;
        send_byte(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(0, 1))), 1'b1);
        repeat ($urandom_range(7, 10))
            send_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b1);
        send_crlf();
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial begin
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.in_byte       = 8'h00;
        in_ch.start_of_body = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extension text, extreme data bytes
        start_pending = 1'b1;
        send_text("2;x");
        send_crlf();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_crlf();
        // repeated cr after the size
        send_text("1");
        send_byte(CH_CR, 1'b1);
        send_crlf();
        send_text("Z");
        send_crlf();
        // size line with no digits
        send_crlf();
        // lf missing after the size
        send_text("1");
        send_byte(CH_CR, 1'b1);
        send_text("X");
        // cr missing after data, then lf missing after data
        send_text("1");
        send_crlf();
        send_text("AX1");
        send_crlf();
        send_text("A");
        send_byte(CH_CR, 1'b1);
        send_text("X");
        // size past the counter width
        send_text("123456789");
        send_crlf();
        send_text("ab");
        // end of body, trailing bytes dropped
        start_pending = 1'b1;
        send_text("0");
        send_crlf();
        send_byte("a", 1'b0);
        send_byte("b", 1'b0);

        while (counted_items < 1850) begin
            idle_on = (counted_items < 1650) && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: send_body(1'b0);
                7: send_body(1'b1);
                8: send_noise();
                default: send_oversize();
            endcase
        end
        in_ch.valid <= 1'b0;

        do @(posedge i_clk); while (pending_results != 0);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** http_chunked_body_decoder_core: PASSED **");
        end else begin
            $display("** http_chunked_body_decoder_core: FAILED **");
        end
        $finish;
    end

endmodule

// ===== http_chunked_body_decoder_core.f =====
+incdir+hdl
hdl/hcbd_pkg.sv
hdl/hcbd_in_if.sv
hdl/hcbd_out_if.sv
hdl/http_chunked_body_decoder_core.sv
tb/hcbd_result_checker.sv
tb/tb_http_chunked_body_decoder_core.sv
